[hw/rtl/itaf_pkg.sv]
// Shared types, constants and character helpers for the integer to ASCII formatter.
package itaf_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DEC_W      = 32;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 16;
  localparam int unsigned DIDX_W     = 4;   // index into the digit buffer
  localparam int unsigned DCNT_W     = 5;   // digit count, 0..16
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0]  CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0]  CHAR_UP_A  = 8'h41;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // Reciprocal of ten, scaled by 2^35, exact for every 32-bit dividend
  localparam logic [DEC_W-1:0] RECIP_TEN = 32'hcccc_cccd;
  localparam int unsigned      RECIP_SH  = 35;

  typedef enum logic [1:0] {
    REQ_SDEC   = 2'd0,
    REQ_UDEC   = 2'd1,
    REQ_HEX_LO = 2'd2,
    REQ_HEX_UP = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXTRACT,
    ST_EMIT
  } state_e;

  // Result of one pass through the digit unit
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rest;
    logic               done;   // nothing left after this digit
  } digit_res_t;

  // Digit value to ASCII code
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d,
                                                      input logic               upper);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_to_char = CHAR_ZERO + ext;
    end else if (upper) begin
      digit_to_char = CHAR_UP_A + ext - 8'd10;
    end else begin
      digit_to_char = CHAR_LO_A + ext - 8'd10;
    end
  endfunction

endpackage

[hw/rtl/integer_to_ascii_formatter_core.sv]
// Top level of the integer to ASCII formatter: sequencer, digit buffer and output register.
//
// Usage:
//   Slave side takes one number per word: tuser = req_type (0 signed decimal,
//   1 unsigned decimal, 2 hex lowercase, 3 hex uppercase); tdata holds value
//   in bits 63..0 and clear_count in bit 64. Decimal modes use value[31:0].
//   Master side gives one ASCII character per word, most significant digit
//   first with no leading zeros; tlast marks the final character of the
//   number, and tdata carries the running saturating character count.
//   Sequence: accept, then extract one digit per cycle through the shared
//   digit unit (1 to 10 decimal, 1 to 16 hex), then emit one character per
//   cycle while the master side does not stall (digits plus an optional
//   minus sign). The sequencer handles one number at a time and
//   s_axis_tready_o is high only while it is idle.
//   A stalled master side holds the current character in the output register
//   and pauses the emit sequence; nothing is lost.
//   Reset clears the sequencer, the output valid and the character count.
module integer_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // [63:0] value, [64] clear_count, [71:65] zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // [7:0] ascii_char, [39:8] char_count
  output logic        m_axis_tlast_o   // last_char
);
  import itaf_pkg::*;

  state_e               state_q, state_d;
  logic [VALUE_W-1:0]   work_q, work_d;
  logic                 hex_q, hex_d;
  logic                 upper_q, upper_d;
  logic                 neg_q, neg_d;
  logic [DCNT_W-1:0]    nd_q, nd_d;
  logic [DCNT_W-1:0]    rd_q, rd_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [DIGIT_W-1:0]   digits_q [MAX_DIGITS];
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;

  logic                 accept;
  logic                 load;
  logic                 emit_last;
  logic                 extract_end;
  logic [COUNT_W-1:0]   count_inc;
  logic [DIDX_W-1:0]    rd_idx;
  logic [DEC_W-1:0]     in_low;
  logic [VALUE_W-1:0]   in_mag;
  logic                 in_neg;
  req_type_e            in_type;
  digit_res_t           dres;

  // Shared digit unit
  itaf_digit_unit u_digit (
    .hex_i   (hex_q),
    .value_i (work_q),
    .res_o   (dres)
  );

  assign in_type   = req_type_e'(s_axis_tuser_i);
  assign in_low    = s_axis_tdata_i[DEC_W-1:0];
  assign in_neg    = (in_type == REQ_SDEC) && in_low[DEC_W-1];
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);
  assign emit_last = !neg_q && (rd_q == DCNT_W'(1));
  assign rd_idx    = DIDX_W'(rd_q - DCNT_W'(1));
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
  assign extract_end = dres.done || (nd_q == DCNT_W'(MAX_DIGITS - 1));

  // Magnitude of the incoming number
  always_comb begin
    case (in_type)
      REQ_SDEC: begin
        in_mag = {{(VALUE_W-DEC_W){1'b0}}, (in_neg ? (~in_low + DEC_W'(1)) : in_low)};
      end
      REQ_UDEC: begin
        in_mag = {{(VALUE_W-DEC_W){1'b0}}, in_low};
      end
      default: begin
        in_mag = s_axis_tdata_i[VALUE_W-1:0];
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXTRACT;
      end
      ST_EXTRACT: begin
        if (extract_end) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and datapath
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    work_d      = work_q;
    hex_d       = hex_q;
    upper_d     = upper_q;
    neg_d       = neg_q;
    nd_d        = nd_q;
    rd_d        = rd_q;
    count_d     = count_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_count_d = out_count_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          work_d  = in_mag;
          hex_d   = (in_type == REQ_HEX_LO) || (in_type == REQ_HEX_UP);
          upper_d = (in_type == REQ_HEX_UP);
          neg_d   = in_neg;
          nd_d    = '0;
          if (s_axis_tdata_i[VALUE_W]) count_d = '0;
        end
      end
      ST_EXTRACT: begin
        work_d = dres.rest;
        nd_d   = nd_q + DCNT_W'(1);
        if (extract_end) rd_d = nd_q + DCNT_W'(1);
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_last_d  = emit_last;
          count_d     = count_inc;
          out_count_d = count_inc;
          if (neg_q) begin
            out_char_d = CHAR_MINUS;
            neg_d      = 1'b0;
          end else begin
            out_char_d = digit_to_char(digits_q[rd_idx], upper_q);
            rd_d       = rd_q - DCNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      nd_q        <= '0;
      rd_q        <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      nd_q        <= nd_d;
      rd_q        <= rd_d;
      neg_q       <= neg_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    work_q      <= work_d;
    hex_q       <= hex_d;
    upper_q     <= upper_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_count_q <= out_count_d;
  end

  // Digit buffer, least significant digit at index zero
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXTRACT) begin
      digits_q[nd_q[DIDX_W-1:0]] <= dres.digit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  // Checks
  a_extract_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXTRACT) |-> (nd_q < DCNT_W'(MAX_DIGITS)))
    else $error("digit buffer overrun");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rd_q != '0))
    else $error("emit with empty digit buffer");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXTRACT) && (nd_q == '0))
    else $error("accepted number did not start extraction");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == COUNT_MAX) && !(accept && s_axis_tdata_i[VALUE_W])
      |=> (count_q == COUNT_MAX))
    else $error("character count wrapped");

endmodule

[hw/rtl/itaf_digit_unit.sv]
// Shared digit extractor: one decimal (divide by ten) or hex (nibble) step per use.
module itaf_digit_unit (
  input  logic                          hex_i,
  input  logic [itaf_pkg::VALUE_W-1:0]  value_i,
  output itaf_pkg::digit_res_t          res_o
);
  import itaf_pkg::*;

  logic [DEC_W-1:0]     dec_in;
  logic [2*DEC_W-1:0]   prod;
  logic [DEC_W-1:0]     quot;
  logic [DEC_W-1:0]     rem_full;
  logic [VALUE_W-1:0]   hex_rest;

  // Divide by ten through the scaled reciprocal, remainder by shift-add
  assign dec_in   = value_i[DEC_W-1:0];
  assign prod     = {{DEC_W{1'b0}}, dec_in} * {{DEC_W{1'b0}}, RECIP_TEN};
  assign quot     = {{RECIP_SH-DEC_W{1'b0}}, prod[2*DEC_W-1:RECIP_SH]};
  assign rem_full = dec_in - ((quot << 3) + (quot << 1));

  assign hex_rest = value_i >> DIGIT_W;

  // Select the step by mode
  always_comb begin
    if (hex_i) begin
      res_o.digit = value_i[DIGIT_W-1:0];
      res_o.rest  = hex_rest;
    end else begin
      res_o.digit = rem_full[DIGIT_W-1:0];
      res_o.rest  = {{(VALUE_W-DEC_W){1'b0}}, quot};
    end
    res_o.done = (res_o.rest == '0);
  end

endmodule
